/* rtl/core/frwla_pkg.sv */
// ----------------------------------------------------------------------------
// frwla_pkg
// Shared types and codes for the reader-writer lock arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package frwla_pkg;

  // Request actions
  localparam logic [1:0] ACT_ACQ_RD = 2'd0;
  localparam logic [1:0] ACT_ACQ_WR = 2'd1;
  localparam logic [1:0] ACT_REL_RD = 2'd2;
  localparam logic [1:0] ACT_REL_WR = 2'd3;

  // Response kinds
  localparam logic [2:0] RSP_GRANT    = 3'd0;
  localparam logic [2:0] RSP_QUEUED   = 3'd1;
  localparam logic [2:0] RSP_RELEASED = 3'd2;
  localparam logic [2:0] RSP_FULL     = 3'd3;
  localparam logic [2:0] RSP_BAD_REL  = 3'd4;

  // Grants given per release at most
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  // One waiting requester
  typedef struct packed {
    logic       wr;
    logic [7:0] id;
  } frwla_entry_t;

  // Queue control from the sequencer to the cell chain
  typedef struct packed {
    logic         shift;
    logic         load;
    frwla_entry_t data;
  } frwla_qctl_t;

endpackage

`default_nettype wire

/* rtl/core/frwla_cell.sv */
// ----------------------------------------------------------------------------
// frwla_cell
// One slot of the wait queue: shifts toward the head or loads a new item.
// ----------------------------------------------------------------------------
`default_nettype none

module frwla_cell
  import frwla_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         shift,
  input  wire logic         load,
  input  wire frwla_entry_t din_new,
  input  wire frwla_entry_t din_next,
  output frwla_entry_t      dout
);

  frwla_entry_t entry_r;
  frwla_entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (shift) begin
      entry_nxt = din_next;
    end else if (load) begin
      entry_nxt = din_new;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign dout = entry_r;

endmodule

`default_nettype wire

/* rtl/core/frwla_queue.sv */
// ----------------------------------------------------------------------------
// frwla_queue
// Wait queue as a chain of cells; cell 0 is the head, new items land at count.
// ----------------------------------------------------------------------------
`default_nettype none

module frwla_queue
  import frwla_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)
(
  input  wire logic             clk,
  input  wire frwla_qctl_t      ctl,
  input  wire logic [CNT_W-1:0] count,
  output frwla_entry_t          head,
  output frwla_entry_t          second
);

  frwla_entry_t q [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    frwla_entry_t nxt_in;
    logic         load_here;

    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nxt_in = q[i+1];
    end else begin : g_end
      assign nxt_in = q[i];
    end

    assign load_here = ctl.load && (count == CNT_W'(i));

    frwla_cell u_cell (
      .clk      (clk),
      .shift    (ctl.shift),
      .load     (load_here),
      .din_new  (ctl.data),
      .din_next (nxt_in),
      .dout     (q[i])
    );
  end

  assign head   = q[0];
  assign second = q[1];

endmodule

`default_nettype wire

/* rtl/core/fifo_reader_writer_lock_arbiter.sv */
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock_arbiter
// First-come first-served reader-writer lock with a FIFO of waiting requesters.
// ----------------------------------------------------------------------------
// Results: a release that starts the wake sequence (last reader out, or a
// release write that frees the writer) gives its N results in order from the
// wake state; any other item gives its one result from the output register.
// Throughput: one item per cycle while the result slot is free; a wake
// sequence holds in_ready low, one grant per cycle off the chain when free.
// Reset (rst_n low, synchronous): lock free, queue empty, no result pending.
`default_nettype none

module fifo_reader_writer_lock_arbiter
  import frwla_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_READERS = 256
)
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_requester_id,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_response_kind,
  output logic [7:0]      out_grant_id,
  output logic            out_grant_is_writer,
  output logic [8:0]      out_active_readers,
  output logic            out_writer_holds,
  output logic            out_last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RD_W  = $clog2(MAX_READERS + 1);
  localparam logic [RES_CNT_W-1:0] RES_LAST = RES_CNT_W'(MAX_RESULTS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAKE = 1'b1;

  logic                 state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [RD_W-1:0]      rd_r, rd_nxt;
  logic                 wr_r, wr_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;
  logic [7:0]           rel_id_r, rel_id_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           kind_r, kind_nxt;
  logic [7:0]           gid_r, gid_nxt;
  logic                 gwr_r, gwr_nxt;
  logic                 last_r, last_nxt;
  logic [RD_W-1:0]      ord_r, ord_nxt;
  logic                 owr_r, owr_nxt;

  frwla_qctl_t          qctl;
  frwla_entry_t         q_head;
  frwla_entry_t         q_second;
  logic                 slot_free;
  logic                 acc;
  logic                 more;
  logic [RD_W+8:0]      rd_ext;

  frwla_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_queue (
    .clk    (clk),
    .ctl    (qctl),
    .count  (cnt_r),
    .head   (q_head),
    .second (q_second)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;

  // Another reader follows this grant only if the next head is a reader and
  // neither the run nor the reader count has hit its limit.
  assign more = (cnt_r >= CNT_W'(2)) && !q_second.wr && (n_r != RES_LAST) &&
                (rd_r < RD_W'(MAX_READERS - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    n_nxt         = n_r;
    rel_id_nxt    = rel_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    gid_nxt       = gid_r;
    gwr_nxt       = gwr_r;
    last_nxt      = last_r;
    ord_nxt       = ord_r;
    owr_nxt       = owr_r;
    qctl.shift    = 1'b0;
    qctl.load     = 1'b0;
    qctl.data.wr  = (in_action == ACT_ACQ_WR);
    qctl.data.id  = in_requester_id;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          gid_nxt       = in_requester_id;
          gwr_nxt       = 1'b0;
          last_nxt      = 1'b1;
          unique case (in_action)
            ACT_ACQ_RD: begin
              if (!wr_r && cnt_r == '0) begin
                if (rd_r == RD_W'(MAX_READERS)) begin
                  kind_nxt = RSP_FULL;
                end else begin
                  kind_nxt = RSP_GRANT;
                  rd_nxt   = rd_r + 1'b1;
                end
              end else if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
                kind_nxt = RSP_FULL;
              end else begin
                kind_nxt  = RSP_QUEUED;
                qctl.load = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            ACT_ACQ_WR: begin
              if (!wr_r && rd_r == '0 && cnt_r == '0) begin
                kind_nxt = RSP_GRANT;
                gwr_nxt  = 1'b1;
                wr_nxt   = 1'b1;
              end else if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
                kind_nxt = RSP_FULL;
              end else begin
                kind_nxt  = RSP_QUEUED;
                qctl.load = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            ACT_REL_RD: begin
              if (rd_r == '0) begin
                kind_nxt = RSP_BAD_REL;
              end else begin
                rd_nxt = rd_r - 1'b1;
                if (rd_r == RD_W'(1)) begin
                  // Last reader out: hand over to the wake sequence
                  out_valid_nxt = out_valid_r && !out_ready;
                  state_nxt     = ST_WAKE;
                  n_nxt         = '0;
                  rel_id_nxt    = in_requester_id;
                end else begin
                  kind_nxt = RSP_RELEASED;
                end
              end
            end
            ACT_REL_WR: begin
              if (!wr_r) begin
                kind_nxt = RSP_BAD_REL;
              end else begin
                wr_nxt        = 1'b0;
                out_valid_nxt = out_valid_r && !out_ready;
                state_nxt     = ST_WAKE;
                n_nxt         = '0;
                rel_id_nxt    = in_requester_id;
              end
            end
            default: begin
              kind_nxt = RSP_BAD_REL;
            end
          endcase
          ord_nxt = rd_nxt;
          owr_nxt = wr_nxt;
        end
      end
      ST_WAKE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (cnt_r != '0 && q_head.wr && n_r == '0 && !wr_r && rd_r == '0) begin
            kind_nxt   = RSP_GRANT;
            gid_nxt    = q_head.id;
            gwr_nxt    = 1'b1;
            last_nxt   = 1'b1;
            qctl.shift = 1'b1;
            cnt_nxt    = cnt_r - 1'b1;
            wr_nxt     = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (cnt_r != '0 && !q_head.wr && !wr_r &&
                       rd_r < RD_W'(MAX_READERS)) begin
            kind_nxt   = RSP_GRANT;
            gid_nxt    = q_head.id;
            gwr_nxt    = 1'b0;
            last_nxt   = !more;
            qctl.shift = 1'b1;
            cnt_nxt    = cnt_r - 1'b1;
            rd_nxt     = rd_r + 1'b1;
            n_nxt      = n_r + 1'b1;
            if (!more) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            // Nothing grantable at the head
            kind_nxt  = RSP_RELEASED;
            gid_nxt   = rel_id_r;
            gwr_nxt   = 1'b0;
            last_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end
          ord_nxt = rd_nxt;
          owr_nxt = wr_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_r        <= '0;
      wr_r        <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_id_r <= rel_id_nxt;
    kind_r   <= kind_nxt;
    gid_r    <= gid_nxt;
    gwr_r    <= gwr_nxt;
    last_r   <= last_nxt;
    ord_r    <= ord_nxt;
    owr_r    <= owr_nxt;
  end

  assign rd_ext = {9'd0, ord_r};

  assign out_valid           = out_valid_r;
  assign out_response_kind   = kind_r;
  assign out_grant_id        = gid_r;
  assign out_grant_is_writer = gwr_r;
  assign out_active_readers  = rd_ext[8:0];
  assign out_writer_holds    = owr_r;
  assign out_last            = last_r;

endmodule

`default_nettype wire
